### design/pmq_pkg.sv
// Shared types, codes and reset values of the PIR motion qualifier.
`default_nettype none

package pmq_pkg;

    // Item modes.
    localparam logic [1:0] MODE_UPDATE = 2'd0;
    localparam logic [1:0] MODE_BLANK  = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    // Vote level that passes the raw sample straight through.
    localparam logic [1:0] VOTE_BYPASS = 2'd0;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_HOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLANK_LENGTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VOTE_LEVEL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SINGLE_SHOT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLANK_ENABLE  = 3'd5;

    // Register reset values.
    localparam logic [15:0] HOLD_RESET       = 16'd150;
    localparam logic [15:0] BLANK_LEN_RESET  = 16'd200;
    localparam logic [15:0] TIMEOUT_RESET    = 16'd5000;
    localparam logic [1:0]  VOTE_LEVEL_RESET = 2'd2;

    // Motion state codes as they appear on the result channel.
    localparam logic [2:0] STATE_IDLE    = 3'd0;
    localparam logic [2:0] STATE_DETECT  = 3'd1;
    localparam logic [2:0] STATE_ACTIVE  = 3'd2;
    localparam logic [2:0] STATE_TIMEOUT = 3'd3;
    localparam logic [2:0] STATE_END     = 3'd4;

    localparam int NOW_W = 32;
    localparam int OUT_W = 32;

    typedef struct packed {
        logic [15:0] debounce_hold_ms;
        logic [15:0] blank_length_ms;
        logic [15:0] idle_timeout_ms;
        logic [1:0]  vote_level;
        logic        single_shot;
        logic        blank_enable;
    } cfg_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic [NOW_W-1:0] now_ms;
        logic             raw_level;
    } item_t;

    typedef struct packed {
        logic [2:0]       state_code;
        logic             motion_level;
        logic             motion_present;
        logic             blanking_active;
        logic             start_event;
        logic             active_event;
        logic             end_event;
        logic [OUT_W-1:0] motion_duration_ms;
        logic [OUT_W-1:0] since_motion_ms;
    } result_t;

    typedef struct packed {
        logic step;
        logic clear;
    } vote_ctrl_t;

endpackage

`default_nettype wire

### design/pmq_vote.sv
// Majority-vote sample ring with write pointer and fill count.
`default_nettype none

module pmq_vote
    import pmq_pkg::*;
#(
    parameter int VOTE_DEPTH = 8
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire vote_ctrl_t ctrl,
    input  wire logic [1:0] vote_level,
    input  wire logic       raw_level,
    output logic            voted
);

    localparam int PW = $clog2(VOTE_DEPTH);
    localparam int FW = $clog2(VOTE_DEPTH + 1);

    logic [VOTE_DEPTH-1:0] ring_reg, ring_next;
    logic [PW-1:0]         ptr_reg, ptr_next;
    logic [FW-1:0]         fill_reg, fill_next;

    logic [4:0]    pow;
    logic          clamp;
    logic [FW-1:0] size;
    logic [PW:0]   ptr_inc;
    logic [PW:0]   size_ext;
    logic [FW-1:0] count;

    always_comb begin
        pow      = 5'd1 << vote_level;
        clamp    = (pow >= 5'(VOTE_DEPTH));
        size     = clamp ? FW'(VOTE_DEPTH) : FW'(pow);
        size_ext = (PW+1)'(size);
        ptr_inc  = {1'b0, ptr_reg} + 1'b1;

        ring_next          = ring_reg;
        ring_next[ptr_reg] = raw_level;

        // A clamped size need not be a power of two, but the pointer then never passes it.
        if (clamp) begin
            ptr_next = (ptr_inc >= size_ext) ? '0 : PW'(ptr_inc);
        end else begin
            ptr_next = PW'(ptr_inc & (size_ext - 1'b1));
        end

        fill_next = (fill_reg < size) ? fill_reg + 1'b1 : fill_reg;

        count = '0;
        for (int i = 0; i < VOTE_DEPTH; i++) begin
            if (FW'(i) < fill_next) begin
                count = count + FW'(ring_next[i]);
            end
        end

        // A tie between high and low samples votes high.
        if (vote_level == VOTE_BYPASS) begin
            voted = raw_level;
        end else begin
            voted = ({1'b0, count, 1'b0} >= {2'b00, fill_next});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            ring_reg <= '0;
            ptr_reg  <= '0;
            fill_reg <= '0;
        end else if (ctrl.step && vote_level != VOTE_BYPASS) begin
            ring_reg <= ring_next;
            ptr_reg  <= ptr_next;
            fill_reg <= fill_next;
        end
    end

endmodule

`default_nettype wire

### design/pmq_tracker.sv
// Blanking window, debounce, motion state machine and timing results.
`default_nettype none

module pmq_tracker
    import pmq_pkg::*;
#(
    parameter int STAMP_WIDTH = 32
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  step,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    input  wire logic  voted,
    output vote_ctrl_t vote_ctrl,
    output result_t    result
);

    typedef enum logic [2:0] {
        S_IDLE    = STATE_IDLE,
        S_DETECT  = STATE_DETECT,
        S_ACTIVE  = STATE_ACTIVE,
        S_TIMEOUT = STATE_TIMEOUT,
        S_END     = STATE_END
    } state_t;

    typedef logic [STAMP_WIDTH-1:0] stamp_t;

    state_t state_reg, state_next;
    logic   level_reg, level_next;
    logic   blank_open_reg, blank_open_next;
    stamp_t change_reg, change_next;
    stamp_t start_reg, start_next;
    stamp_t end_reg, end_next;
    stamp_t blank_stamp_reg, blank_stamp_next;

    stamp_t now_s;
    stamp_t dur;
    stamp_t since;
    logic   blank_expired;
    logic   hold_met;
    logic   timeout_met;
    logic   run;
    logic   clear_all;
    logic   ev_start, ev_active, ev_end;
    logic   vote_step;

    assign now_s = STAMP_WIDTH'(item.now_ms);

    always_comb begin
        blank_expired = ((now_s - blank_stamp_reg) >= STAMP_WIDTH'(cfg.blank_length_ms));
        hold_met      = ((now_s - change_reg) >= STAMP_WIDTH'(cfg.debounce_hold_ms));
        timeout_met   = ((now_s - end_reg) >= STAMP_WIDTH'(cfg.idle_timeout_ms));

        state_next       = state_reg;
        level_next       = level_reg;
        blank_open_next  = blank_open_reg;
        change_next      = change_reg;
        start_next       = start_reg;
        end_next         = end_reg;
        blank_stamp_next = blank_stamp_reg;
        run              = 1'b0;
        clear_all        = 1'b0;
        ev_start         = 1'b0;
        ev_active        = 1'b0;
        ev_end           = 1'b0;

        case (item.mode)
            MODE_BLANK: begin
                if (cfg.blank_enable) begin
                    blank_open_next  = 1'b1;
                    blank_stamp_next = now_s;
                end
            end
            MODE_CLEAR: begin
                clear_all = 1'b1;
            end
            MODE_UPDATE: begin
                // An expired window closes and the same update goes on normally.
                run = !blank_open_reg || blank_expired;
                if (blank_open_reg && blank_expired) begin
                    blank_open_next = 1'b0;
                end
            end
            default: ;
        endcase

        if (run) begin
            if (voted != level_reg) begin
                if (hold_met) begin
                    level_next  = voted;
                    change_next = now_s;
                end
            end else begin
                change_next = now_s;
            end

            case (state_reg)
                S_IDLE: begin
                    if (level_next) begin
                        state_next = S_DETECT;
                        start_next = now_s;
                        ev_start   = 1'b1;
                    end
                end
                S_DETECT: begin
                    if (level_next) begin
                        state_next = S_ACTIVE;
                        ev_active  = 1'b1;
                    end else begin
                        state_next = S_IDLE;
                        start_next = '0;
                    end
                end
                S_ACTIVE: begin
                    end_next = now_s;
                    if (level_next) begin
                        ev_active = 1'b1;
                    end else begin
                        state_next = S_TIMEOUT;
                    end
                end
                S_TIMEOUT: begin
                    if (level_next) begin
                        state_next = S_ACTIVE;
                    end else if (timeout_met) begin
                        state_next = S_END;
                    end
                end
                default: begin
                    ev_end     = 1'b1;
                    state_next = S_IDLE;
                    start_next = '0;
                    end_next   = '0;
                    clear_all  = cfg.single_shot;
                end
            endcase
        end

        if (clear_all) begin
            state_next      = S_IDLE;
            level_next      = 1'b0;
            start_next      = '0;
            end_next        = '0;
            blank_open_next = 1'b0;
        end

        dur = '0;
        if (start_next != '0) begin
            if (state_next == S_DETECT || state_next == S_ACTIVE) begin
                dur = now_s - start_next;
            end else if (end_next != '0) begin
                dur = end_next - start_next;
            end
        end
        since = (end_next != '0) ? now_s - end_next : '0;
    end

    assign vote_step       = step && run;
    assign vote_ctrl.step  = vote_step;
    assign vote_ctrl.clear = step && clear_all;

    always_comb begin
        result.state_code         = state_next;
        result.motion_level       = level_next;
        result.motion_present     = (state_next == S_DETECT) || (state_next == S_ACTIVE);
        result.blanking_active    = blank_open_next;
        result.start_event        = ev_start;
        result.active_event       = ev_active;
        result.end_event          = ev_end;
        result.motion_duration_ms = OUT_W'(dur);
        result.since_motion_ms    = OUT_W'(since);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            level_reg       <= 1'b0;
            blank_open_reg  <= 1'b0;
            change_reg      <= '0;
            start_reg       <= '0;
            end_reg         <= '0;
            blank_stamp_reg <= '0;
        end else if (step) begin
            state_reg       <= state_next;
            level_reg       <= level_next;
            blank_open_reg  <= blank_open_next;
            change_reg      <= change_next;
            start_reg       <= start_next;
            end_reg         <= end_next;
            blank_stamp_reg <= blank_stamp_next;
        end
    end

endmodule

`default_nettype wire

### design/pir_motion_qualifier_top.sv
// Top level of the PIR motion qualifier: registers, input stage and result stage.
//
//  Channel   Direction  Handshake              Payload
//  s_        in         s_valid / s_ready      s_mode, s_now_ms, s_raw_level
//  m_        out        m_valid / m_ready      state, level, events, duration, since
//  cfg_      in         cfg_wr_en              cfg_index, cfg_wdata
//
// Each beat is held in the input register and then waits in the result register,
// which offers its result; one beat is taken every cycle while the result register is not stalled.
// State updates as a beat moves from the input register to the result register.
// Reset is synchronous and leaves the block idle with registers at their defaults.
// A stalled result register holds the input register, which then lowers s_ready.
`default_nettype none

module pir_motion_qualifier_top
    import pmq_pkg::*;
#(
    parameter int VOTE_DEPTH  = 8,
    parameter int STAMP_WIDTH = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [1:0]            s_mode,
    input  wire logic [NOW_W-1:0]      s_now_ms,
    input  wire logic                  s_raw_level,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [2:0]                 m_state_code,
    output logic                       m_motion_level,
    output logic                       m_motion_present,
    output logic                       m_blanking_active,
    output logic                       m_start_event,
    output logic                       m_active_event,
    output logic                       m_end_event,
    output logic [OUT_W-1:0]           m_motion_duration_ms,
    output logic [OUT_W-1:0]           m_since_motion_ms,

    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    item_t      in_item_reg;
    logic       out_valid_reg;
    result_t    out_res_reg;

    logic       advance;
    logic       voted;
    vote_ctrl_t vote_ctrl;
    result_t    result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_hold_ms <= HOLD_RESET;
            cfg_reg.blank_length_ms  <= BLANK_LEN_RESET;
            cfg_reg.idle_timeout_ms  <= TIMEOUT_RESET;
            cfg_reg.vote_level       <= VOTE_LEVEL_RESET;
            cfg_reg.single_shot      <= 1'b0;
            cfg_reg.blank_enable     <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DEBOUNCE_HOLD: cfg_reg.debounce_hold_ms <= cfg_wdata;
                REG_BLANK_LENGTH:  cfg_reg.blank_length_ms  <= cfg_wdata;
                REG_IDLE_TIMEOUT:  cfg_reg.idle_timeout_ms  <= cfg_wdata;
                REG_VOTE_LEVEL:    cfg_reg.vote_level       <= cfg_wdata[1:0];
                REG_SINGLE_SHOT:   cfg_reg.single_shot      <= cfg_wdata[0];
                REG_BLANK_ENABLE:  cfg_reg.blank_enable     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg.mode      <= s_mode;
            in_item_reg.now_ms    <= s_now_ms;
            in_item_reg.raw_level <= s_raw_level;
        end
        if (advance) begin
            out_res_reg <= result;
        end
    end

    pmq_vote #(
        .VOTE_DEPTH (VOTE_DEPTH)
    ) u_vote (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (vote_ctrl),
        .vote_level (cfg_reg.vote_level),
        .raw_level  (in_item_reg.raw_level),
        .voted      (voted)
    );

    pmq_tracker #(
        .STAMP_WIDTH (STAMP_WIDTH)
    ) u_tracker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .item      (in_item_reg),
        .cfg       (cfg_reg),
        .voted     (voted),
        .vote_ctrl (vote_ctrl),
        .result    (result)
    );

    assign m_valid              = out_valid_reg;
    assign m_state_code         = out_res_reg.state_code;
    assign m_motion_level       = out_res_reg.motion_level;
    assign m_motion_present     = out_res_reg.motion_present;
    assign m_blanking_active    = out_res_reg.blanking_active;
    assign m_start_event        = out_res_reg.start_event;
    assign m_active_event       = out_res_reg.active_event;
    assign m_end_event          = out_res_reg.end_event;
    assign m_motion_duration_ms = out_res_reg.motion_duration_ms;
    assign m_since_motion_ms    = out_res_reg.since_motion_ms;

    // The input stage only refuses a beat while it holds one that cannot move on.
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stage stalled without a blocked result");

    // At most one event per result beat.
    a_single_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0({m_start_event, m_active_event, m_end_event}))
        else $error("more than one event in a result beat");

    // A start event always lands in the detected state.
    a_start_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_start_event) |-> (m_state_code == STATE_DETECT))
        else $error("start event outside the detected state");

    // An end event always returns the machine to idle.
    a_end_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_end_event) |-> (m_state_code == STATE_IDLE && !m_motion_present))
        else $error("end event without return to idle");

endmodule

`default_nettype wire
